// File: hdl/cft_pkg.sv
// Shared types, constants and arithmetic helpers of the circle fan tessellator.
package cft_pkg;

  localparam int DETAIL_LEVELS  = 7;
  localparam int UNIT_FRAC_BITS = 14;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 16;
  localparam int COLOR_W  = 32;
  localparam int LEVEL_W  = 3;
  localparam int SEG_W    = 6;
  localparam int ANGLE_W  = 7;
  localparam int SINE_IDX_W = 5;

  // Angles are counted in steps of 5 degrees; a quarter turn is 18 steps.
  localparam int QUARTER   = 18;
  localparam int FULL_TURN = 4 * QUARTER;

  localparam int UNIT_W = UNIT_FRAC_BITS + 2;
  localparam int PROD_W = UNIT_W + RADIUS_W + 1;
  localparam int SUM_W  = COORD_W + 2;

  localparam int QUEUE_DEPTH = 2;  // power of two, pointers wrap naturally
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [RADIUS_W-1:0]       radius_t;
  typedef logic [COLOR_W-1:0]        color_t;
  typedef logic [LEVEL_W-1:0]        level_t;
  typedef logic [SEG_W-1:0]          seg_t;
  typedef logic [ANGLE_W-1:0]        angle_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  localparam radius_t MIN_RADIUS = 16'd90;

  typedef radius_t bound_tab_t [0:DETAIL_LEVELS-2];
  localparam bound_tab_t LEVEL_BOUND = '{16'd564, 16'd1280, 16'd2304,
                                         16'd3840, 16'd7168, 16'd10240};

  typedef seg_t seg_tab_t [0:DETAIL_LEVELS-1];
  localparam seg_tab_t SEG_COUNT = '{6'd4, 6'd6, 6'd8, 6'd12, 6'd18, 6'd24, 6'd36};

  // Angle advance per segment, 72 / segment count.
  typedef angle_t step_tab_t [0:DETAIL_LEVELS-1];
  localparam step_tab_t ANGLE_STEP = '{7'd18, 7'd12, 7'd9, 7'd6, 7'd4, 7'd3, 7'd2};

  // sin(5*k degrees) scaled by 1e9, k = 0..18.
  typedef int unsigned sine_e9_t [0:QUARTER];
  localparam sine_e9_t SINE_E9 = '{
    0, 87155743, 173648178, 258819045, 342020143, 422618262,
    500000000, 573576436, 642787610, 707106781, 766044443,
    819152044, 866025404, 906307787, 939692621, 965925826,
    984807753, 996194698, 1000000000};

  localparam longint unsigned Billion = 64'd1000000000;
  localparam longint unsigned HalfBillion = 64'd500000000;

  typedef unit_t sine_tab_t [0:QUARTER];

  // Quarter-wave table, rounded to nearest in Q1.UNIT_FRAC_BITS.
  function automatic sine_tab_t build_sine();
    sine_tab_t t;
    longint unsigned v;
    for (int j = 0; j <= QUARTER; j++) begin
      v = (64'(SINE_E9[j]) << UNIT_FRAC_BITS) + HalfBillion;
      t[j] = UNIT_W'(v / Billion);
    end
    return t;
  endfunction

  localparam sine_tab_t SINE_Q = build_sine();

  typedef struct packed {
    unit_t c;
    unit_t s;
  } unit_vec_t;

  typedef struct packed {
    coord_t  cx;
    coord_t  cy;
    radius_t r;
    color_t  rgba;
    level_t  level;
  } circle_entry_t;

  typedef struct packed {
    logic can_push;
    logic has_item;
  } queue_stat_t;

  localparam logic signed [PROD_W:0]  ROUND_HALF = (PROD_W+1)'(1 << (UNIT_FRAC_BITS - 1));
  localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'((1 << (COORD_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(1 << (COORD_W - 1));

  // A radius below a bound belongs to the lower level.
  function automatic level_t level_of(radius_t r);
    level_t lv;
    lv = '0;
    for (int j = 0; j < DETAIL_LEVELS - 1; j++) begin
      if (r >= LEVEL_BOUND[j]) lv = LEVEL_W'(j + 1);
    end
    return lv;
  endfunction

  // Unit vector at angle k (5-degree steps, 0 up to a full turn minus one).
  function automatic unit_vec_t unit_vec(angle_t k);
    logic [1:0] q;
    logic [SINE_IDX_W-1:0] rr;
    unit_t c0;
    unit_t s0;
    unit_vec_t v;
    if (k >= ANGLE_W'(3 * QUARTER)) begin
      q = 2'd3;
      rr = SINE_IDX_W'(k - ANGLE_W'(3 * QUARTER));
    end else if (k >= ANGLE_W'(2 * QUARTER)) begin
      q = 2'd2;
      rr = SINE_IDX_W'(k - ANGLE_W'(2 * QUARTER));
    end else if (k >= ANGLE_W'(QUARTER)) begin
      q = 2'd1;
      rr = SINE_IDX_W'(k - ANGLE_W'(QUARTER));
    end else begin
      q = 2'd0;
      rr = SINE_IDX_W'(k);
    end
    c0 = SINE_Q[SINE_IDX_W'(QUARTER) - rr];
    s0 = SINE_Q[rr];
    unique case (q)
      2'd0: begin v.c = c0;  v.s = s0;  end
      2'd1: begin v.c = -s0; v.s = c0;  end
      2'd2: begin v.c = -c0; v.s = -s0; end
      2'd3: begin v.c = s0;  v.s = -c0; end
    endcase
    return v;
  endfunction

  // Round the offset to Q.8 with ties upward, add the center and saturate.
  function automatic coord_t vertex(coord_t c, prod_t p);
    logic signed [PROD_W:0] pr;
    logic signed [SUM_W-1:0] s;
    pr = {p[PROD_W-1], p} + ROUND_HALF;
    pr = pr >>> UNIT_FRAC_BITS;
    s = SUM_W'(pr) + SUM_W'(c);
    if (s > SAT_HI) s = SAT_HI;
    if (s < SAT_LO) s = SAT_LO;
    return COORD_W'(s);
  endfunction

endpackage

// File: hdl/cft_circle_if.sv
// Input channel interface: one circle per transfer.
interface cft_circle_if;
  logic                valid;
  logic                ready;
  cft_pkg::coord_t     center_x;
  cft_pkg::coord_t     center_y;
  cft_pkg::radius_t    radius;
  cft_pkg::color_t     rgba;

  modport source (output valid, center_x, center_y, radius, rgba, input ready);
  modport sink   (input valid, center_x, center_y, radius, rgba, output ready);
endinterface

// File: hdl/cft_tri_if.sv
// Output channel interface: one triangle per transfer.
interface cft_tri_if;
  logic             valid;
  logic             ready;
  cft_pkg::coord_t  hub_x;
  cft_pkg::coord_t  hub_y;
  cft_pkg::coord_t  lead_x;
  cft_pkg::coord_t  lead_y;
  cft_pkg::coord_t  trail_x;
  cft_pkg::coord_t  trail_y;
  cft_pkg::color_t  tri_color;
  logic             last_triangle;

  modport source (output valid, hub_x, hub_y, lead_x, lead_y, trail_x, trail_y,
                  tri_color, last_triangle, input ready);
  modport sink   (input valid, hub_x, hub_y, lead_x, lead_y, trail_x, trail_y,
                  tri_color, last_triangle, output ready);
endinterface

// File: hdl/circle_fan_tessellator.sv
// Top level of the circle fan tessellator: front end, queue and back end.
//
//   channel     dir   transfer moves                       handshake
//   circles     in    center_x, center_y, radius, rgba      valid / ready
//   triangles   out   hub, lead, trail vertices, color,     valid / ready
//                     last_triangle
//
// A circle of n segments (4 to 36, set by its radius) gives n triangles, one per
// cycle while the triangle side does not stall. A circle passes the front register
// and the queue, and its triangles the back-end pipeline stages. A radius below
// 90/256 pixel is taken and gives nothing.
// Reset is synchronous and empties the front register, the queue and the pipeline.
// Each stage moves on only when the one after it is empty or moving, so a stall at
// the triangle side holds everything; the front keeps taking circles until its
// register and the two-entry queue are full.
module circle_fan_tessellator (
  input  logic       clk,
  input  logic       rst,
  cft_circle_if.sink circles,
  cft_tri_if.source  triangles
);

  cft_pkg::queue_stat_t   q_stat;
  cft_pkg::circle_entry_t push_data;
  cft_pkg::circle_entry_t head;
  logic                   push;
  logic                   pop;

  // The front end classifies each circle and holds it until the queue has room.
  cft_front u_front (
    .clk       (clk),
    .rst       (rst),
    .circles   (circles),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // The queue lets the front take new circles while the back end is busy.
  cft_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The back end pops a circle once its final segment has entered the pipeline.
  cft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .triangles (triangles)
  );

endmodule

// File: hdl/cft_front.sv
// Front end: takes circles, drops tiny ones and picks the level of detail.
module cft_front (
  input  logic                   clk,
  input  logic                   rst,
  cft_circle_if.sink             circles,
  input  cft_pkg::queue_stat_t   q_stat,
  output logic                   push,
  output cft_pkg::circle_entry_t push_data
);

  logic                   held_valid;
  cft_pkg::circle_entry_t held;
  logic                   take;
  logic                   keep;

  assign push      = held_valid && q_stat.can_push;
  assign push_data = held;

  assign circles.ready = !held_valid || q_stat.can_push;
  assign take = circles.valid && circles.ready;
  assign keep = take && (circles.radius >= cft_pkg::MIN_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (keep) begin
      held_valid <= 1'b1;
    end else if (push) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      held.cx    <= circles.center_x;
      held.cy    <= circles.center_y;
      held.r     <= circles.radius;
      held.rgba  <= circles.rgba;
      held.level <= cft_pkg::level_of(circles.radius);
    end
  end

endmodule

// File: hdl/cft_queue.sv
// Short FIFO of classified circles between the front and back ends.
module cft_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  cft_pkg::circle_entry_t push_data,
  input  logic                   pop,
  output cft_pkg::circle_entry_t head,
  output cft_pkg::queue_stat_t   q_stat
);

  cft_pkg::circle_entry_t            mem [cft_pkg::QUEUE_DEPTH];
  logic [cft_pkg::QPTR_W-1:0]        wr_ptr;
  logic [cft_pkg::QPTR_W-1:0]        rd_ptr;
  logic [cft_pkg::QPTR_W:0]          count;
  logic                              do_push;
  logic                              do_pop;

  assign q_stat.can_push = (count != (cft_pkg::QPTR_W + 1)'(cft_pkg::QUEUE_DEPTH));
  assign q_stat.has_item = (count != '0);
  assign do_push = push && q_stat.can_push;
  assign do_pop  = pop && q_stat.has_item;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: hdl/cft_back.sv
// Back end: walks the segments of the head circle through a three-stage pipeline.
module cft_back (
  input  logic                   clk,
  input  logic                   rst,
  input  cft_pkg::circle_entry_t head,
  input  cft_pkg::queue_stat_t   q_stat,
  output logic                   pop,
  cft_tri_if.source              triangles
);

  typedef struct packed {
    cft_pkg::coord_t    cx;
    cft_pkg::coord_t    cy;
    cft_pkg::radius_t   r;
    cft_pkg::color_t    rgba;
    cft_pkg::unit_vec_t lead;
    cft_pkg::unit_vec_t trail;
    logic               last;
  } stage1_t;

  typedef struct packed {
    cft_pkg::coord_t  cx;
    cft_pkg::coord_t  cy;
    cft_pkg::color_t  rgba;
    cft_pkg::prod_t   lead_px;
    cft_pkg::prod_t   lead_py;
    cft_pkg::prod_t   trail_px;
    cft_pkg::prod_t   trail_py;
    logic             last;
  } stage2_t;

  cft_pkg::seg_t   seg;
  cft_pkg::angle_t angle;
  cft_pkg::angle_t lead_angle;
  cft_pkg::angle_t step;
  logic            last_seg;
  logic            issue;

  logic    v1, v2, v3;
  logic    en1, en2, en3;
  stage1_t s1;
  stage2_t s2;
  logic signed [cft_pkg::RADIUS_W:0] r_signed;

  assign en3 = !v3 || triangles.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign step     = cft_pkg::ANGLE_STEP[head.level];
  assign last_seg = (seg == cft_pkg::SEG_COUNT[head.level] - 1'b1);
  assign issue    = q_stat.has_item && en1;
  assign pop      = issue && last_seg;

  // The angle after the last segment wraps to zero, which closes the fan.
  always_comb begin
    lead_angle = angle + step;
    if (lead_angle == cft_pkg::ANGLE_W'(cft_pkg::FULL_TURN)) lead_angle = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg   <= '0;
      angle <= '0;
    end else if (issue) begin
      if (last_seg) begin
        seg   <= '0;
        angle <= '0;
      end else begin
        seg   <= seg + 1'b1;
        angle <= lead_angle;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= issue;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1.cx    <= head.cx;
      s1.cy    <= head.cy;
      s1.r     <= head.r;
      s1.rgba  <= head.rgba;
      s1.lead  <= cft_pkg::unit_vec(lead_angle);
      s1.trail <= cft_pkg::unit_vec(angle);
      s1.last  <= last_seg;
    end
  end

  assign r_signed = signed'({1'b0, s1.r});

  always_ff @(posedge clk) begin
    if (en2) begin
      s2.cx       <= s1.cx;
      s2.cy       <= s1.cy;
      s2.rgba     <= s1.rgba;
      s2.lead_px  <= cft_pkg::PROD_W'(s1.lead.c) * cft_pkg::PROD_W'(r_signed);
      s2.lead_py  <= cft_pkg::PROD_W'(s1.lead.s) * cft_pkg::PROD_W'(r_signed);
      s2.trail_px <= cft_pkg::PROD_W'(s1.trail.c) * cft_pkg::PROD_W'(r_signed);
      s2.trail_py <= cft_pkg::PROD_W'(s1.trail.s) * cft_pkg::PROD_W'(r_signed);
      s2.last     <= s1.last;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      triangles.hub_x         <= s2.cx;
      triangles.hub_y         <= s2.cy;
      triangles.lead_x        <= cft_pkg::vertex(s2.cx, s2.lead_px);
      triangles.lead_y        <= cft_pkg::vertex(s2.cy, s2.lead_py);
      triangles.trail_x       <= cft_pkg::vertex(s2.cx, s2.trail_px);
      triangles.trail_y       <= cft_pkg::vertex(s2.cy, s2.trail_py);
      triangles.tri_color     <= s2.rgba;
      triangles.last_triangle <= s2.last;
    end
  end

  assign triangles.valid = v3;

endmodule

// File: hdl/cft_checker.sv
// Port-level checks of the circle fan tessellator, bound to its top level.
module cft_checker (
  input logic            clk,
  input logic            rst,
  input logic            circ_ready,
  input logic            tri_valid,
  input logic            tri_ready,
  input logic            tri_last,
  input cft_pkg::coord_t lead_x,
  input cft_pkg::coord_t trail_y,
  input cft_pkg::color_t tri_color
);

  // A stalled triangle keeps its contents.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    tri_valid && !tri_ready |=> tri_valid && $stable(lead_x) && $stable(trail_y)
      && $stable(tri_color) && $stable(tri_last))
    else $error("stalled triangle changed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !tri_valid)
    else $error("triangle offered right after reset");

  // Reset empties the front register, so circles are taken at once.
  a_reset_ready: assert property (@(posedge clk)
    rst |=> circ_ready)
    else $error("circle side not ready after reset");

  // The segments of one circle follow each other with no gap.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    tri_valid && tri_ready && !tri_last |=> tri_valid)
    else $error("gap inside a triangle fan");

endmodule

bind circle_fan_tessellator cft_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .circ_ready (circles.ready),
  .tri_valid  (triangles.valid),
  .tri_ready  (triangles.ready),
  .tri_last   (triangles.last_triangle),
  .lead_x     (triangles.lead_x),
  .trail_y    (triangles.trail_y),
  .tri_color  (triangles.tri_color)
);
